FILE: hdl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// shared constants and types for the overwriting window buffer
// ----------------------------------------------------------------------------
package owb_pkg;

    // storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // fixed field widths
    localparam int FUNC_BITS   = 2;
    localparam int WORD_BITS   = 32;
    localparam int LEN_BITS    = 7;
    localparam int POS_BITS    = 6;
    localparam int STATUS_BITS = 2;
    localparam int CNT_BITS    = 32;
    localparam int INDEX_BITS  = 8;
    localparam int CFG_BITS    = 7;

    // stored word width, words are masked to both the data and the field width
    localparam int STORE_BITS = (DATA_BITS < WORD_BITS) ? DATA_BITS : WORD_BITS;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_SNAP  = 2'd1,
        FUNC_FLUSH = 2'd2
    } func_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_DROPPED   = 2'd1,
        STAT_CLOSED    = 2'd2,
        STAT_BAD_COUNT = 2'd3
    } status_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_CLOSED     = 8'd0,
        REG_WINDOW_LEN = 8'd1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } state_t;

    // one result as held in the output register
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [WORD_BITS-1:0]   data_out;
        logic [POS_BITS-1:0]    position;
        logic                   has_data;
        logic                   last;
        logic [LEN_BITS-1:0]    length;
        logic [CNT_BITS-1:0]    total_put;
        logic [CNT_BITS-1:0]    total_dropped;
        logic [LEN_BITS-1:0]    peak_length;
    } rsp_t;

endpackage

FILE: hdl/owb_if.sv
// ----------------------------------------------------------------------------
// owb interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface owb_req_if;
    logic                           valid;
    logic                           ready;
    logic [owb_pkg::FUNC_BITS-1:0]  func;
    logic [owb_pkg::WORD_BITS-1:0]  data_in;
    logic [owb_pkg::LEN_BITS-1:0]   want_count;
    logic                           emit_on_flush;

    modport source (output valid, func, data_in, want_count, emit_on_flush, input ready);
    modport sink   (input valid, func, data_in, want_count, emit_on_flush, output ready);
endinterface

interface owb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [owb_pkg::STATUS_BITS-1:0]  status;
    logic [owb_pkg::WORD_BITS-1:0]    data_out;
    logic [owb_pkg::POS_BITS-1:0]     position;
    logic                             has_data;
    logic                             last;
    logic [owb_pkg::LEN_BITS-1:0]     length;
    logic [owb_pkg::CNT_BITS-1:0]     total_put;
    logic [owb_pkg::CNT_BITS-1:0]     total_dropped;
    logic [owb_pkg::LEN_BITS-1:0]     peak_length;

    modport source (output valid, status, data_out, position, has_data, last, length,
                    total_put, total_dropped, peak_length, input ready);
    modport sink   (input valid, status, data_out, position, has_data, last, length,
                    total_put, total_dropped, peak_length, output ready);
endinterface

interface owb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [owb_pkg::INDEX_BITS-1:0]  index;
    logic [owb_pkg::CFG_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/owb_ram.sv
// ----------------------------------------------------------------------------
// owb_ram
// entry store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module owb_ram (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [owb_pkg::ADDR_BITS-1:0]   wr_addr,
    input  logic [owb_pkg::STORE_BITS-1:0]  wr_data,
    input  logic                            rd_en,
    input  logic [owb_pkg::ADDR_BITS-1:0]   rd_addr,
    output logic [owb_pkg::STORE_BITS-1:0]  rd_data
);

    logic [owb_pkg::STORE_BITS-1:0] mem [owb_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/overwrite_window_buffer_core.sv
// ----------------------------------------------------------------------------
// overwrite_window_buffer_core
// sliding-window ring buffer that keeps the newest entries
// ----------------------------------------------------------------------------
// Each request is a put, a snapshot or a flush. A put, a refused put, a bad
// snapshot count, a snapshot or flush that yields no entries and an unused
// function code each give one result; such requests can follow each other
// every cycle as long as results are taken. A snapshot of m entries or a
// flush that emits m entries streams its results out of the single read port
// of the entry store: the request loads the read address register, the store
// reads each entry into its read data register, and from there it moves into
// the output register, one entry per cycle while the result side takes them.
// No new request is taken until the last entry of a stream is in the output
// register. Entries are never cleared; only written entries can be read.
// Configuration writes are always taken, but must only be issued while the
// block is idle; writing the window length empties the window and keeps the
// counters and the peak.
// ----------------------------------------------------------------------------
module overwrite_window_buffer_core (
    input  logic       clk,
    input  logic       rst_n,
    owb_req_if.sink    req,
    owb_rsp_if.source  rsp,
    owb_cfg_if.sink    cfg
);

    localparam int AW = owb_pkg::ADDR_BITS;
    localparam int LW = owb_pkg::LEN_BITS;

    // advance a ring pointer within the active window
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] inc;
        inc = LW'(ptr) + LW'(1);
        return (inc >= len) ? '0 : inc[AW-1:0];
    endfunction

    // configuration
    logic                closed_reg;
    logic [LW-1:0]       win_len_reg;

    // window state
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [AW-1:0]       next_ptr_reg, next_ptr_next;
    logic [LW-1:0]       fill_reg, fill_next;
    logic [owb_pkg::CNT_BITS-1:0] put_cnt_reg, put_cnt_next;
    logic [owb_pkg::CNT_BITS-1:0] drop_cnt_reg, drop_cnt_next;
    logic [LW-1:0]       peak_reg, peak_next;

    // stream control
    owb_pkg::state_t     state_reg, state_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [LW-1:0]       rd_left_reg, rd_left_next;
    logic [LW-1:0]       emit_left_reg, emit_left_next;
    logic [owb_pkg::POS_BITS-1:0] pos_reg, pos_next;
    logic                rd_pending_reg, rd_pending_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    owb_pkg::rsp_t       out_reg, out_next;

    // handshakes
    logic                out_free;
    logic                in_ready;
    logic                accept;
    logic                cfg_write;

    // memory ports
    logic                wr_en;
    logic                rd_en;
    logic [owb_pkg::STORE_BITS-1:0] rd_data;

    // request decode
    logic                full;
    logic [AW-1:0]       oldest_inc;
    logic [LW-1:0]       fill_put;
    logic [LW-1:0]       peak_put;
    logic [LW-1:0]       snap_m;
    logic [LW-1:0]       snap_start;
    logic                stream_load;
    logic                stream_issue;
    logic [LW-1:0]       cfg_len;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && in_ready;
    assign cfg_write = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    // result port straight from the output register
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.data_out      = out_reg.data_out;
    assign rsp.position      = out_reg.position;
    assign rsp.has_data      = out_reg.has_data;
    assign rsp.last          = out_reg.last;
    assign rsp.length        = out_reg.length;
    assign rsp.total_put     = out_reg.total_put;
    assign rsp.total_dropped = out_reg.total_dropped;
    assign rsp.peak_length   = out_reg.peak_length;

    // put arithmetic: drop oldest first when the window is full
    assign full       = fill_reg >= win_len_reg;
    assign oldest_inc = wrap_inc(oldest_reg, win_len_reg);
    assign fill_put   = full ? fill_reg : fill_reg + LW'(1);
    assign peak_put   = (fill_put > peak_reg) ? fill_put : peak_reg;

    // snapshot: newest m entries start at oldest + (fill - m), folded once
    always_comb
    begin
        logic [LW-1:0] sum;
        snap_m = (req.want_count < fill_reg) ? req.want_count : fill_reg;
        sum    = LW'(oldest_reg) + (fill_reg - snap_m);
        snap_start = (sum >= win_len_reg) ? sum - win_len_reg : sum;
    end

    // clamp of the window length write
    always_comb
    begin
        cfg_len = cfg.data;
        if (cfg_len < LW'(1))
        begin
            cfg_len = LW'(1);
        end
        if (cfg_len > LW'(owb_pkg::DEPTH))
        begin
            cfg_len = LW'(owb_pkg::DEPTH);
        end
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            owb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (owb_pkg::func_t'(req.func))
                        owb_pkg::FUNC_SNAP:
                        begin
                            if (req.want_count != '0 && snap_m != '0)
                            begin
                                state_next = owb_pkg::ST_STREAM;
                            end
                        end
                        owb_pkg::FUNC_FLUSH:
                        begin
                            if (req.emit_on_flush && fill_reg != '0)
                            begin
                                state_next = owb_pkg::ST_STREAM;
                            end
                        end
                        default:
                        begin
                            state_next = owb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            owb_pkg::ST_STREAM:
            begin
                // leave once the final entry enters the output register
                if (stream_load && emit_left_reg == LW'(1))
                begin
                    state_next = owb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = owb_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        in_ready     = 1'b0;
        stream_load  = 1'b0;
        stream_issue = 1'b0;
        case (state_reg)
            owb_pkg::ST_IDLE:
            begin
                in_ready = out_free;
            end
            owb_pkg::ST_STREAM:
            begin
                // read data waiting in the store output moves on when free,
                // and the next read goes out as soon as that data slot frees
                stream_load  = rd_pending_reg && out_free;
                stream_issue = (rd_left_reg != '0) && (!rd_pending_reg || stream_load);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        oldest_next     = oldest_reg;
        next_ptr_next   = next_ptr_reg;
        fill_next       = fill_reg;
        put_cnt_next    = put_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        peak_next       = peak_reg;
        rd_addr_next    = rd_addr_reg;
        rd_left_next    = rd_left_reg;
        emit_left_next  = emit_left_reg;
        pos_next        = pos_reg;
        rd_pending_next = rd_pending_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        wr_en           = 1'b0;

        // single result defaults, counters as they stand
        if (accept)
        begin
            out_valid_next         = 1'b1;
            out_next.status        = owb_pkg::STAT_OK;
            out_next.data_out      = '0;
            out_next.position      = '0;
            out_next.has_data      = 1'b0;
            out_next.last          = 1'b1;
            out_next.length        = fill_reg;
            out_next.total_put     = put_cnt_reg;
            out_next.total_dropped = drop_cnt_reg;
            out_next.peak_length   = peak_reg;

            case (owb_pkg::func_t'(req.func))
                owb_pkg::FUNC_PUT:
                begin
                    if (closed_reg)
                    begin
                        out_next.status = owb_pkg::STAT_CLOSED;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        next_ptr_next = wrap_inc(next_ptr_reg, win_len_reg);
                        fill_next     = fill_put;
                        put_cnt_next  = put_cnt_reg + owb_pkg::CNT_BITS'(1);
                        peak_next     = peak_put;
                        if (full)
                        begin
                            oldest_next     = oldest_inc;
                            drop_cnt_next   = drop_cnt_reg + owb_pkg::CNT_BITS'(1);
                            out_next.status = owb_pkg::STAT_DROPPED;
                        end
                        out_next.length        = fill_put;
                        out_next.total_put     = put_cnt_reg + owb_pkg::CNT_BITS'(1);
                        out_next.total_dropped = full ? drop_cnt_reg + owb_pkg::CNT_BITS'(1)
                                                      : drop_cnt_reg;
                        out_next.peak_length   = peak_put;
                    end
                end
                owb_pkg::FUNC_SNAP:
                begin
                    if (req.want_count == '0)
                    begin
                        out_next.status = owb_pkg::STAT_BAD_COUNT;
                    end
                    else if (snap_m != '0)
                    begin
                        out_valid_next  = out_valid_reg && !rsp.ready;
                        out_next        = out_reg;
                        rd_addr_next    = snap_start[AW-1:0];
                        rd_left_next    = snap_m;
                        emit_left_next  = snap_m;
                        pos_next        = '0;
                        rd_pending_next = 1'b0;
                    end
                end
                owb_pkg::FUNC_FLUSH:
                begin
                    oldest_next     = '0;
                    next_ptr_next   = '0;
                    fill_next       = '0;
                    out_next.length = '0;
                    if (req.emit_on_flush && fill_reg != '0)
                    begin
                        out_valid_next  = out_valid_reg && !rsp.ready;
                        out_next        = out_reg;
                        rd_addr_next    = oldest_reg;
                        rd_left_next    = fill_reg;
                        emit_left_next  = fill_reg;
                        pos_next        = '0;
                        rd_pending_next = 1'b0;
                    end
                end
                default:
                begin
                    out_next.status = owb_pkg::STAT_OK;
                end
            endcase
        end

        // streamed entries, length already reflects any flush
        if (stream_load)
        begin
            out_valid_next         = 1'b1;
            out_next.status        = owb_pkg::STAT_OK;
            out_next.data_out      = owb_pkg::WORD_BITS'(rd_data);
            out_next.position      = pos_reg;
            out_next.has_data      = 1'b1;
            out_next.last          = (emit_left_reg == LW'(1));
            out_next.length        = fill_reg;
            out_next.total_put     = put_cnt_reg;
            out_next.total_dropped = drop_cnt_reg;
            out_next.peak_length   = peak_reg;
            pos_next               = pos_reg + owb_pkg::POS_BITS'(1);
            emit_left_next         = emit_left_reg - LW'(1);
        end

        if (state_reg == owb_pkg::ST_STREAM)
        begin
            rd_pending_next = stream_issue || (rd_pending_reg && !stream_load);
        end

        if (stream_issue)
        begin
            rd_addr_next = wrap_inc(rd_addr_reg, win_len_reg);
            rd_left_next = rd_left_reg - LW'(1);
        end

        // window length write empties the window
        if (cfg_write && cfg.index == owb_pkg::REG_WINDOW_LEN)
        begin
            oldest_next   = '0;
            next_ptr_next = '0;
            fill_next     = '0;
        end
    end

    assign rd_en = stream_issue;

    owb_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (next_ptr_reg),
        .wr_data (req.data_in[owb_pkg::STORE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg  <= 1'b0;
            win_len_reg <= LW'(owb_pkg::DEPTH);
        end
        else if (cfg_write)
        begin
            case (owb_pkg::reg_index_t'(cfg.index))
                owb_pkg::REG_CLOSED:
                begin
                    closed_reg <= cfg.data[0];
                end
                owb_pkg::REG_WINDOW_LEN:
                begin
                    win_len_reg <= cfg_len;
                end
                default:
                begin
                    closed_reg <= closed_reg;
                end
            endcase
        end
    end

    // window state, stream control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= owb_pkg::ST_IDLE;
            oldest_reg     <= '0;
            next_ptr_reg   <= '0;
            fill_reg       <= '0;
            put_cnt_reg    <= '0;
            drop_cnt_reg   <= '0;
            peak_reg       <= '0;
            rd_left_reg    <= '0;
            emit_left_reg  <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            next_ptr_reg   <= next_ptr_next;
            fill_reg       <= fill_next;
            put_cnt_reg    <= put_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            peak_reg       <= peak_next;
            rd_left_reg    <= rd_left_next;
            emit_left_reg  <= emit_left_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        pos_reg     <= pos_next;
        out_reg     <= out_next;
    end

endmodule
